FILE: src/dirty_rect_merge_tracker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dirty rectangle merge tracker
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef DIRTY_RECT_MERGE_TRACKER_MACROS_SVH
`define DIRTY_RECT_MERGE_TRACKER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define DRM_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("drm check failed: same-cycle implication");
// Next-cycle implication under an active-low reset.
`define DRM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("drm check failed: next-cycle implication");
`else
`define DRM_ASSERT_IMPL(label, ck, rn, ante, cons)
`define DRM_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

FILE: src/drm_pkg.sv
// ---------------------------------------------------------------------------
// drm_pkg
// Types, constants and sequencer states shared by the merge tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 13;
    localparam int AREA_W      = 29;
    localparam int PROD_W      = 2 * SIZE_W;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_IDX_W   = 1;

    localparam int CANVAS_MAX     = 4096;
    localparam int MAX_RECTS_DEF  = 16;
    localparam int MERGE_GAP_DEF  = 2;
    localparam int RESULT_CAP     = 16;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    localparam logic [SIZE_W-1:0] CANVAS_W_RST = 13'd1072;
    localparam logic [SIZE_W-1:0] CANVAS_H_RST = 13'd1448;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } box_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SEARCH,
        ST_COLLAPSE,
        ST_FOLD_RD,
        ST_FOLD_CK,
        ST_FOLD_MV,
        ST_SUM,
        ST_REPORT,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } state_t;

endpackage

`default_nettype wire

FILE: src/drm_box_unit.sv
// ---------------------------------------------------------------------------
// drm_box_unit
// Shared proximity test and bounding-box join of two rectangles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drm_box_unit
    import drm_pkg::*;
#(
    parameter int MERGE_GAP = MERGE_GAP_DEF
)
(
    input  box_t a,
    input  box_t b,
    output logic near,
    output box_t joined
);

    // edges never pass the canvas limit, plus the gap for the test
    localparam int EW = $clog2(CANVAS_MAX + MERGE_GAP + 1);
    localparam logic [EW-1:0] GAP = EW'(MERGE_GAP);

    logic [EW-1:0]      ax1, bx1, ay1, by1;
    logic [EW-1:0]      ex, ey;
    logic [COORD_W-1:0] jx, jy;

    assign ax1 = EW'(a.x) + EW'(a.w);
    assign bx1 = EW'(b.x) + EW'(b.w);
    assign ay1 = EW'(a.y) + EW'(a.h);
    assign by1 = EW'(b.y) + EW'(b.h);

    assign near = (EW'(a.x) <= bx1 + GAP) && (EW'(b.x) <= ax1 + GAP) &&
                  (EW'(a.y) <= by1 + GAP) && (EW'(b.y) <= ay1 + GAP);

    always_comb
    begin
        jx = (a.x < b.x) ? a.x : b.x;
        jy = (a.y < b.y) ? a.y : b.y;
        ex = (ax1 > bx1) ? ax1 : bx1;
        ey = (ay1 > by1) ? ay1 : by1;
        joined.x = jx;
        joined.y = jy;
        joined.w = SIZE_W'(ex - EW'(jx));
        joined.h = SIZE_W'(ey - EW'(jy));
    end

endmodule

`default_nettype wire

FILE: src/dirty_rect_merge_tracker.sv
// ---------------------------------------------------------------------------
// dirty_rect_merge_tracker
// Dirty rectangle table with clip, near-merge, fold pass and drain.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid / in_ready  | action, rect_x/y/w/h, mono
//  out     | source    | out_valid / out_ready| out_x/y/w/h, count, area, flags
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One table write port, one read port and one box unit serve every pass. An
//  add scans the stored entries and, without a merge, appends; a merge adds the
//  fold pass. A drain reads one table entry per emitted beat.
//  in_ready is high only between items; a finished beat waits in the output
//  register while the next item is taken. No clearing pass after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dirty_rect_merge_tracker_macros.svh"

module dirty_rect_merge_tracker
    import drm_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int MERGE_GAP = MERGE_GAP_DEF
)
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    action,
    input  wire signed [15:0]      rect_x,
    input  wire signed [15:0]      rect_y,
    input  wire signed [15:0]      rect_w,
    input  wire signed [15:0]      rect_h,
    input  wire                    mono_damage,

    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [COORD_W-1:0]     out_x,
    output logic [COORD_W-1:0]     out_y,
    output logic [SIZE_W-1:0]      out_w,
    output logic [SIZE_W-1:0]      out_h,
    output logic [COUNT_OUT_W-1:0] stored_count,
    output logic [AREA_W-1:0]      area_sum,
    output logic                   gray_flag,
    output logic                   last_item,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [SIZE_W-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg,  scan_next;
    logic [CW-1:0] idx1_reg,  idx1_next;
    logic [CW-1:0] mi_reg,    mi_next;
    logic [CW-1:0] fj_reg,    fj_next;
    logic          v1_reg,    v1_next;
    logic          v2_reg,    v2_next;
    box_t          acc_reg,   acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic          gray_reg,  gray_next;

    logic [SIZE_W-1:0] canvas_w_reg, canvas_h_reg;

    logic signed [15:0] in_x_reg, in_y_reg, in_w_reg, in_h_reg;
    logic               in_mono_reg;

    box_t                   out_box_reg,   out_box_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [AREA_W-1:0]      out_area_reg,  out_area_next;
    logic                   out_gray_reg,  out_gray_next;
    logic                   out_last_reg,  out_last_next;
    logic                   out_valid_reg;
    logic                   load_out;

    box_t          rect_mem [MAX_RECTS];
    box_t          rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    box_t          mem_wd;
    logic [IW-1:0] rd_addr;

    logic          near;
    box_t          joined;
    logic          issue;
    logic          slot_free;
    logic          drain_last;
    logic [CW-1:0] scan_plus;
    logic [CW-1:0] last_idx;
    logic [AREA_W:0] area_add;

    // clip datapath
    logic [SIZE_W-1:0]  cw_lim, ch_lim;
    logic signed [16:0] xs, ys, ws, hs, cws, chs;
    logic signed [16:0] x0, y0, x1r, y1r, x1, y1, dx, dy;
    logic               clip_empty;
    box_t               clip_box;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;
    assign issue     = (scan_reg < count_reg);
    assign scan_plus = scan_reg + CW'(1);
    assign last_idx  = count_reg - CW'(1);
    assign drain_last = (count_reg == '0) || (scan_plus == count_reg) ||
                        ({1'b0, scan_plus} == (CW + 1)'(RESULT_CAP));
    assign area_add  = {1'b0, area_reg} + (AREA_W + 1)'(prod_reg);

    drm_box_unit #(
        .MERGE_GAP (MERGE_GAP)
    ) u_box (
        .a      (acc_reg),
        .b      (rd_data_reg),
        .near   (near),
        .joined (joined)
    );

    always_comb
    begin
        cw_lim = (canvas_w_reg > SIZE_W'(CANVAS_MAX)) ? SIZE_W'(CANVAS_MAX) : canvas_w_reg;
        ch_lim = (canvas_h_reg > SIZE_W'(CANVAS_MAX)) ? SIZE_W'(CANVAS_MAX) : canvas_h_reg;
        xs  = $signed({in_x_reg[15], in_x_reg});
        ys  = $signed({in_y_reg[15], in_y_reg});
        ws  = $signed({in_w_reg[15], in_w_reg});
        hs  = $signed({in_h_reg[15], in_h_reg});
        cws = $signed({4'b0000, cw_lim});
        chs = $signed({4'b0000, ch_lim});
        x0  = xs[16] ? 17'sd0 : xs;
        y0  = ys[16] ? 17'sd0 : ys;
        x1r = xs + ws;
        y1r = ys + hs;
        x1  = (x1r > cws) ? cws : x1r;
        y1  = (y1r > chs) ? chs : y1r;
        dx  = x1 - x0;
        dy  = y1 - y0;
        clip_empty = in_w_reg[15] || (in_w_reg == 16'sd0) ||
                     in_h_reg[15] || (in_h_reg == 16'sd0) ||
                     (cw_lim == '0) || (ch_lim == '0) ||
                     (x1 <= x0) || (y1 <= y0);
        clip_box.x = x0[COORD_W-1:0];
        clip_box.y = y0[COORD_W-1:0];
        clip_box.w = dx[SIZE_W-1:0];
        clip_box.h = dy[SIZE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        idx1_next      = idx1_reg;
        mi_next        = mi_reg;
        fj_next        = fj_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        area_next      = area_reg;
        gray_next      = gray_reg;
        mem_we         = 1'b0;
        mem_wa         = count_reg[IW-1:0];
        mem_wd         = acc_reg;
        rd_addr        = scan_reg[IW-1:0];
        load_out       = 1'b0;
        out_box_next   = acc_reg;
        out_count_next = COUNT_OUT_W'(count_reg);
        out_area_next  = area_reg;
        out_gray_next  = gray_reg;
        out_last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    scan_next  = '0;
                    v1_next    = 1'b0;
                    state_next = action ? ST_DRAIN_RD : ST_CLIP;
                end
            end

            ST_CLIP:
            begin
                scan_next = '0;
                v1_next   = 1'b0;
                if (clip_empty)
                begin
                    // nothing stored changes; just report current bounds
                    v2_next    = 1'b0;
                    acc_next   = '0;
                    area_next  = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    acc_next = clip_box;
                    if (!in_mono_reg)
                        gray_next = 1'b1;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (v1_reg && near)
                begin
                    acc_next   = joined;
                    mi_next    = idx1_reg;
                    fj_next    = '0;
                    v1_next    = 1'b0;
                    state_next = ST_FOLD_RD;
                end
                else if (!v1_reg && !issue)
                begin
                    if (count_reg < CW'(MAX_RECTS))
                    begin
                        // append at the tail
                        mem_we     = 1'b1;
                        mem_wa     = count_reg[IW-1:0];
                        mem_wd     = acc_reg;
                        count_next = count_reg + CW'(1);
                        scan_next  = '0;
                        v2_next    = 1'b0;
                        acc_next   = '0;
                        area_next  = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = ST_COLLAPSE;
                    end
                end
                else
                begin
                    v1_next   = issue;
                    idx1_next = scan_reg;
                    if (issue)
                        scan_next = scan_plus;
                end
            end

            ST_COLLAPSE:
            begin
                if (v1_reg)
                    acc_next = joined;
                if (!v1_reg && !issue)
                begin
                    // table full: keep one bounding box
                    mem_we     = 1'b1;
                    mem_wa     = '0;
                    mem_wd     = acc_reg;
                    count_next = CW'(1);
                    scan_next  = '0;
                    v2_next    = 1'b0;
                    acc_next   = '0;
                    area_next  = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    v1_next   = issue;
                    idx1_next = scan_reg;
                    if (issue)
                        scan_next = scan_plus;
                end
            end

            ST_FOLD_RD:
            begin
                rd_addr = fj_reg[IW-1:0];
                if (fj_reg == count_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = mi_reg[IW-1:0];
                    mem_wd     = acc_reg;
                    scan_next  = '0;
                    v1_next    = 1'b0;
                    v2_next    = 1'b0;
                    acc_next   = '0;
                    area_next  = '0;
                    state_next = ST_SUM;
                end
                else if (fj_reg == mi_reg)
                begin
                    fj_next = fj_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_FOLD_CK;
                end
            end

            ST_FOLD_CK:
            begin
                // fetch the tail in case this entry gets swap-removed
                rd_addr = last_idx[IW-1:0];
                if (near)
                begin
                    acc_next = joined;
                    if (mi_reg == last_idx)
                    begin
                        // merge target was the tail: it now lives at j
                        mi_next    = fj_reg;
                        count_next = last_idx;
                        state_next = ST_FOLD_RD;
                    end
                    else
                    begin
                        state_next = ST_FOLD_MV;
                    end
                end
                else
                begin
                    fj_next    = fj_reg + CW'(1);
                    state_next = ST_FOLD_RD;
                end
            end

            ST_FOLD_MV:
            begin
                mem_we     = 1'b1;
                mem_wa     = fj_reg[IW-1:0];
                mem_wd     = rd_data_reg;
                count_next = last_idx;
                state_next = ST_FOLD_RD;
            end

            ST_SUM:
            begin
                if (v1_reg)
                begin
                    acc_next  = (idx1_reg == '0) ? rd_data_reg : joined;
                    prod_next = PROD_W'(rd_data_reg.w) * PROD_W'(rd_data_reg.h);
                end
                if (v2_reg)
                    area_next = area_add[AREA_W] ? AREA_MAX : area_add[AREA_W-1:0];
                v2_next = v1_reg;
                if (!v1_reg && !v2_reg && !issue)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    v1_next   = issue;
                    idx1_next = scan_reg;
                    if (issue)
                        scan_next = scan_plus;
                end
            end

            ST_REPORT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN_RD:
            begin
                state_next = ST_DRAIN_LD;
            end

            ST_DRAIN_LD:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    out_box_next  = (count_reg == '0) ? '0 : rd_data_reg;
                    out_last_next = drain_last;
                    if (drain_last)
                    begin
                        count_next = '0;
                        area_next  = '0;
                        gray_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_plus;
                        state_next = ST_DRAIN_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            idx1_reg      <= '0;
            mi_reg        <= '0;
            fj_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            area_reg      <= '0;
            gray_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            canvas_w_reg  <= CANVAS_W_RST;
            canvas_h_reg  <= CANVAS_H_RST;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            idx1_reg  <= idx1_next;
            mi_reg    <= mi_next;
            fj_reg    <= fj_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            area_reg  <= area_next;
            gray_reg  <= gray_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CANVAS_W)
                    canvas_w_reg <= cfg_data;
                else if (cfg_index == CFG_CANVAS_H)
                    canvas_h_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (in_valid && in_ready)
        begin
            in_x_reg    <= rect_x;
            in_y_reg    <= rect_y;
            in_w_reg    <= rect_w;
            in_h_reg    <= rect_h;
            in_mono_reg <= mono_damage;
        end
        if (load_out)
        begin
            out_box_reg   <= out_box_next;
            out_count_reg <= out_count_next;
            out_area_reg  <= out_area_next;
            out_gray_reg  <= out_gray_next;
            out_last_reg  <= out_last_next;
        end
    end

    // rectangle table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rect_mem[mem_wa] <= mem_wd;
        rd_data_reg <= rect_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_box_reg.x;
    assign out_y        = out_box_reg.y;
    assign out_w        = out_box_reg.w;
    assign out_h        = out_box_reg.h;
    assign stored_count = out_count_reg;
    assign area_sum     = out_area_reg;
    assign gray_flag    = out_gray_reg;
    assign last_item    = out_last_reg;

    `DRM_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_RECTS))
    `DRM_ASSERT_IMPL(a_fold_target, clk, rst_n, state_reg == ST_FOLD_RD, mi_reg < count_reg)
    `DRM_ASSERT_IMPL(a_empty_report, clk, rst_n, (state_reg == ST_REPORT) && (count_reg == '0), (area_reg == '0) && (acc_reg == '0))
    `DRM_ASSERT_NEXT(a_drain_clears, clk, rst_n, (state_reg == ST_DRAIN_LD) && slot_free && drain_last, (count_reg == '0) && (area_reg == '0) && !gray_reg)

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench for dirty_rect_merge_tracker
// Drives add and drain items through the valid/ready input channel and
// rewrites the canvas size between phases. It keeps its own copy of the
// rectangle table to predict every report beat, then checks each beat field
// by field. Both channels idle in random bursts, except in the final phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import drm_pkg::*;

    localparam int TRACK_DEPTH    = 16;
    localparam int NEAR_GAP       = 2;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        int x;
        int y;
        int w;
        int h;
    } damage_box_t;

    typedef struct packed {
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [SIZE_W-1:0]      w;
        logic [SIZE_W-1:0]      h;
        logic [COUNT_OUT_W-1:0] count;
        logic [AREA_W-1:0]      area;
        logic                   gray;
        logic                   last;
    } tracker_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   action = 1'b0;
    logic signed [15:0]     rect_x = '0;
    logic signed [15:0]     rect_y = '0;
    logic signed [15:0]     rect_w = '0;
    logic signed [15:0]     rect_h = '0;
    logic                   mono_damage = 1'b0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [COORD_W-1:0]     out_x;
    logic [COORD_W-1:0]     out_y;
    logic [SIZE_W-1:0]      out_w;
    logic [SIZE_W-1:0]      out_h;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic [AREA_W-1:0]      area_sum;
    logic                   gray_flag;
    logic                   last_item;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_CANVAS_W;
    logic [SIZE_W-1:0]      cfg_data = '0;

    // shadow of the tracker state
    damage_box_t            held_boxes [TRACK_DEPTH];
    int                     held_count = 0;
    longint                 held_area = 0;
    logic                   held_gray = 1'b0;
    logic [SIZE_W-1:0]      canvas_w_reg = CANVAS_W_RST;
    logic [SIZE_W-1:0]      canvas_h_reg = CANVAS_H_RST;

    tracker_report_t        expected_reports [$];

    logic                   idle_on = 1'b1;
    int                     mismatch_count = 0;
    int                     items_sent = 0;
    int                     reports_seen = 0;
    int                     canvas_settings = 1;
    int                     quiet_cycles = 0;

    always #1 clk = ~clk;

    dirty_rect_merge_tracker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_w       (rect_w),
        .rect_h       (rect_h),
        .mono_damage  (mono_damage),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_w        (out_w),
        .out_h        (out_h),
        .stored_count (stored_count),
        .area_sum     (area_sum),
        .gray_flag    (gray_flag),
        .last_item    (last_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // tracker prediction
    // ------------------------------------------------------------------
    function automatic int eff_canvas(input logic [SIZE_W-1:0] v);
        return (v > CANVAS_MAX) ? CANVAS_MAX : int'(v);
    endfunction

    function automatic logic boxes_near(input damage_box_t a, input damage_box_t b);
        return a.x <= b.x + b.w + NEAR_GAP && b.x <= a.x + a.w + NEAR_GAP &&
               a.y <= b.y + b.h + NEAR_GAP && b.y <= a.y + a.h + NEAR_GAP;
    endfunction

    function automatic damage_box_t box_union(input damage_box_t a, input damage_box_t b);
        damage_box_t u;
        int          right;
        int          bottom;
        u.x    = (a.x < b.x) ? a.x : b.x;
        u.y    = (a.y < b.y) ? a.y : b.y;
        right  = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
        bottom = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
        u.w    = right - u.x;
        u.h    = bottom - u.y;
        return u;
    endfunction

    function automatic tracker_report_t make_report(input damage_box_t b, input int cnt,
                                                    input longint area, input logic gray,
                                                    input logic last);
        tracker_report_t r;
        r.x     = b.x[COORD_W-1:0];
        r.y     = b.y[COORD_W-1:0];
        r.w     = b.w[SIZE_W-1:0];
        r.h     = b.h[SIZE_W-1:0];
        r.count = cnt[COUNT_OUT_W-1:0];
        r.area  = area[AREA_W-1:0];
        r.gray  = gray;
        r.last  = last;
        return r;
    endfunction

    task automatic recount_area();
        longint acc;
        acc = 0;
        for (int k = 0; k < held_count; k++)
            acc += longint'(held_boxes[k].w) * held_boxes[k].h;
        held_area = (acc > longint'(AREA_MAX)) ? longint'(AREA_MAX) : acc;
    endtask

    // clip, merge into the first near entry, fold further near entries
    task automatic apply_damage(input logic [15:0] px, input logic [15:0] py,
                                input logic [15:0] pw, input logic [15:0] ph,
                                input logic mono);
        damage_box_t r;
        int          x, y, w, h, cw, ch, x0, y0, x1, y1, i, j;
        logic        merged;
        x  = $signed(px);
        y  = $signed(py);
        w  = $signed(pw);
        h  = $signed(ph);
        cw = eff_canvas(canvas_w_reg);
        ch = eff_canvas(canvas_h_reg);
        if (w <= 0 || h <= 0 || cw <= 0 || ch <= 0)
            return;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + w > cw) ? cw : x + w;
        y1 = (y + h > ch) ? ch : y + h;
        if (x1 <= x0 || y1 <= y0)
            return;
        r.x = x0;
        r.y = y0;
        r.w = x1 - x0;
        r.h = y1 - y0;
        if (!mono)
            held_gray = 1'b1;

        i = 0;
        merged = 1'b0;
        while (!merged && i < held_count)
        begin
            if (boxes_near(held_boxes[i], r))
            begin
                held_boxes[i] = box_union(held_boxes[i], r);
                j = 0;
                while (j < held_count)
                begin
                    if (j != i && boxes_near(held_boxes[i], held_boxes[j]))
                    begin
                        // swap-remove; follow the merged entry if it was the one moved
                        held_boxes[i] = box_union(held_boxes[i], held_boxes[j]);
                        held_boxes[j] = held_boxes[held_count-1];
                        held_count--;
                        if (i == held_count)
                            i = j;
                    end
                    else
                        j++;
                end
                merged = 1'b1;
            end
            else
                i++;
        end

        if (!merged)
        begin
            if (held_count < TRACK_DEPTH)
            begin
                held_boxes[held_count] = r;
                held_count++;
            end
            else
            begin
                for (int k = 0; k < held_count; k++)
                    r = box_union(r, held_boxes[k]);
                held_boxes[0] = r;
                held_count = 1;
            end
        end
        recount_area();
    endtask

    task automatic predict_item(input logic act, input logic [15:0] px, input logic [15:0] py,
                                input logic [15:0] pw, input logic [15:0] ph,
                                input logic mono);
        damage_box_t zero_box;
        damage_box_t bounds;
        int          n;
        zero_box = '0;
        if (act)
        begin
            n = (held_count > RESULT_CAP) ? RESULT_CAP : held_count;
            if (n == 0)
                expected_reports.push_back(make_report(zero_box, 0, 0, held_gray, 1'b1));
            for (int k = 0; k < n; k++)
                expected_reports.push_back(make_report(held_boxes[k], held_count, held_area,
                                                       held_gray, k == n - 1));
            held_count = 0;
            held_area  = 0;
            held_gray  = 1'b0;
        end
        else
        begin
            apply_damage(px, py, pw, ph, mono);
            bounds = zero_box;
            if (held_count > 0)
            begin
                bounds = held_boxes[0];
                for (int k = 1; k < held_count; k++)
                    bounds = box_union(bounds, held_boxes[k]);
            end
            expected_reports.push_back(make_report(bounds, held_count, held_area,
                                                   held_gray, 1'b1));
        end
    endtask

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic act, input int x, input int y, input int w,
                             input int h, input logic mono);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        rect_x      <= x[15:0];
        rect_y      <= y[15:0];
        rect_w      <= w[15:0];
        rect_h      <= h[15:0];
        mono_damage <= mono;
        do @(posedge clk); while (!in_ready);
        predict_item(act, x[15:0], y[15:0], w[15:0], h[15:0], mono);
        items_sent++;
    endtask

    // drop valid, let every report come back, then give the block time to go idle
    task automatic wait_tracker_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_canvas(input int wv, input int hv);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CANVAS_W;
        cfg_data  <= wv[SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        canvas_w_reg = wv[SIZE_W-1:0];
        cfg_index <= CFG_CANVAS_H;
        cfg_data  <= hv[SIZE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        canvas_h_reg = hv[SIZE_W-1:0];
        cfg_valid <= 1'b0;
        canvas_settings++;
    endtask

    // sink side stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // report checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_report();
        tracker_report_t want;
        reports_seen++;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: report beat expected none actual x=%0d y=%0d w=%0d h=%0d count=%0d",
                     $time, out_x, out_y, out_w, out_h, stored_count);
            mismatch_count++;
        end
        else
        begin
            want = expected_reports.pop_front();
            compare_field("out_x", longint'(want.x), longint'(out_x));
            compare_field("out_y", longint'(want.y), longint'(out_y));
            compare_field("out_w", longint'(want.w), longint'(out_w));
            compare_field("out_h", longint'(want.h), longint'(out_h));
            compare_field("stored_count", longint'(want.count), longint'(stored_count));
            compare_field("area_sum", longint'(want.area), longint'(area_sum));
            compare_field("gray_flag", longint'(want.gray), longint'(gray_flag));
            compare_field("last_item", longint'(want.last), longint'(last_item));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_report();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d reports outstanding",
                         $time, quiet_cycles, expected_reports.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------
    task automatic scatter_add(input int cw, input int ch);
        int x, y, w, h;
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cw) : $urandom_range(1, 10);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ch) : $urandom_range(1, 10);
        x = int'($urandom_range(0, cw + 6)) - 6;
        y = int'($urandom_range(0, ch + 6)) - 6;
        send_item(1'b0, x, y, w, h, 1'($urandom_range(0, 1)));
    endtask

    // fill a 5x4 grid of far-apart spots; past sixteen spots the table collapses
    task automatic grid_sequence(input int cw, input int ch, input int spots);
        int bx, by, first, grid_slot;
        bx    = $urandom_range(0, cw - 64);
        by    = $urandom_range(0, ch - 48);
        first = $urandom_range(0, 19);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        for (int k = 0; k < spots; k++)
        begin
            grid_slot = (first + 7 * k) % 20;
            send_item(1'b0, bx + (grid_slot % 5) * 12 + $urandom_range(0, 2),
                      by + (grid_slot / 5) * 12 + $urandom_range(0, 2),
                      $urandom_range(1, 4), $urandom_range(1, 4), 1'($urandom_range(0, 1)));
        end
        // sweep over the whole grid so the fold pass eats every entry
        if ($urandom_range(0, 2) == 0)
            send_item(1'b0, bx, by, 60, 48, 1'($urandom_range(0, 1)));
        send_item(1'b1, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_mix(input int n_items, input int grid_pct);
        int start, pick, cw, ch;
        start = items_sent;
        cw    = eff_canvas(canvas_w_reg);
        ch    = eff_canvas(canvas_h_reg);
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < grid_pct && cw >= 64 && ch >= 48)
                grid_sequence(cw, ch, $urandom_range(0, 1) ? $urandom_range(14, 20)
                                                            : $urandom_range(2, 13));
            else if (pick < 72)
                scatter_add(cw, ch);
            else if (pick < 85)
                send_item(1'b1, $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            else
                send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_drain();
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_clip_edges();
        send_item(1'b0, -32768, -32768, 32767, 32767, 1'b0);
        send_item(1'b0, 0, 0, 32767, 32767, 1'b1);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        send_item(1'b0, 32767, 32767, 1, 1, 1'b0);
        send_item(1'b0, -10, -3, 15, 8, 1'b0);
        send_item(1'b0, 1071, 1447, 32767, 32767, 1'b1);
        send_item(1'b0, 50, 50, 0, 5, 1'b0);
        send_item(1'b0, 50, 50, -1, 5, 1'b0);
        send_item(1'b0, 50, 50, 5, -32768, 1'b0);
        send_item(1'b0, 100, 100, -32768, -32768, 1'b0);
        send_item(1'b0, 1072, 0, 5, 5, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 1'b1);
    endtask

    task automatic test_merge_and_fold();
        // merge at a gap of exactly two, append at three, fold with swap-remove
        send_item(1'b0, 10, 10, 4, 4, 1'b1);
        send_item(1'b0, 16, 10, 3, 3, 1'b1);
        send_item(1'b0, 22, 10, 2, 2, 1'b1);
        send_item(1'b0, 40, 10, 2, 2, 1'b1);
        send_item(1'b0, 60, 40, 3, 3, 1'b1);
        send_item(1'b0, 20, 12, 1, 1, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        // merge into the last entry, whose growth then reaches the first one
        send_item(1'b0, 10, 10, 2, 2, 1'b1);
        send_item(1'b0, 100, 100, 3, 3, 1'b1);
        send_item(1'b0, 12, 30, 2, 2, 1'b1);
        send_item(1'b0, 15, 14, 2, 20, 1'b1);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_canvas_limits();
        wait_tracker_idle();
        set_canvas(0, 0);
        send_item(1'b0, 0, 0, 100, 100, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        wait_tracker_idle();
        set_canvas(8191, 8191);
        send_item(1'b0, 0, 0, 32767, 32767, 1'b0);
        send_item(1'b0, 4095, 4095, 32767, 32767, 1'b1);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        wait_tracker_idle();
        set_canvas(1, 1);
        send_item(1'b0, -1, -1, 3, 3, 1'b1);
        send_item(1'b0, 0, 0, 1, 1, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        wait_tracker_idle();
        set_canvas(4097, 1);
        send_item(1'b0, -100, -5, 32767, 32767, 1'b0);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
        wait_tracker_idle();
        set_canvas(1, 4096);
        send_item(1'b0, -32768, -32768, 32767, 32767, 1'b0);
        send_item(1'b0, 0, 4000, 2, 200, 1'b1);
        send_item(1'b1, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_random_small_canvas();
        wait_tracker_idle();
        set_canvas(64, 48);
        random_mix(70, 15);
    endtask

    task automatic test_random_canvas_mix();
        for (int k = 0; k < 3; k++)
        begin
            wait_tracker_idle();
            if (k == 2)
                set_canvas($urandom_range(1, 80), $urandom_range(1, 80));
            else
                set_canvas($urandom_range(1, 4096), $urandom_range(1, 4096));
            random_mix(30, 10);
        end
    endtask

    task automatic test_table_fill_large();
        wait_tracker_idle();
        set_canvas(4096, 4096);
        grid_sequence(4096, 4096, 20);
        random_mix(40, 25);
    endtask

    task automatic test_final_no_idle();
        wait_tracker_idle();
        idle_on = 1'b0;
        set_canvas(int'(CANVAS_W_RST), int'(CANVAS_H_RST));
        random_mix(60, 15);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_drain();
        test_clip_edges();
        test_merge_and_fold();
        test_canvas_limits();
        test_random_small_canvas();
        test_random_canvas_mix();
        test_table_fill_large();
        test_final_no_idle();
        wait_tracker_idle();
        $display("run covered %0d input beats and %0d report beats over %0d canvas settings",
                 items_sent, reports_seen, canvas_settings);
        $display("clipping, gap merges, fold passes, full-table collapse and drains exercised");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
